// ===== rtl/bqap_pkg.sv =====
package bqap_pkg;

  localparam int BQ_NUM_CHANNELS   = 8;
  localparam int BQ_COEF_FRAC_BITS = 15;

  localparam int SAMPLE_BITS = 24;
  localparam int CHAN_W      = 3;
  localparam int COEF_W      = 18;
  localparam int STATE_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic        [CHAN_W-1:0]      chan_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic        [CHAN_W-1:0]      chan_out;
  } out_beat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LDX,
    ACC_SUB,
    ACC_LDP,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    C_B0,
    C_B1,
    C_B2,
    C_A1,
    C_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    O_W1,
    O_W2,
    O_W
  } opd_sel_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT_IN,
    J_CHK_CH,
    J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic      in_rdy;
    logic      ld_delay;
    acc_op_t   acc_op;
    coef_sel_t coef_sel;
    opd_sel_t  opd_sel;
    logic      ld_w;
    logic      ram_we;
    logic      out_ld;
    jmp_t      jmp;
    step_t     target;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic ch_ok;
    logic out_free;
  } seq_stat_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_LOAD = 4'd1;
  localparam step_t ST_MA1  = 4'd2;
  localparam step_t ST_SA1  = 4'd3;
  localparam step_t ST_SA2  = 4'd4;
  localparam step_t ST_RW   = 4'd5;
  localparam step_t ST_AB2  = 4'd6;
  localparam step_t ST_AB0  = 4'd7;
  localparam step_t ST_OUT  = 4'd8;

  localparam cw_t CW_NOP = '{
    in_rdy:   1'b0,
    ld_delay: 1'b0,
    acc_op:   ACC_HOLD,
    coef_sel: C_A1,
    opd_sel:  O_W1,
    ld_w:     1'b0,
    ram_we:   1'b0,
    out_ld:   1'b0,
    jmp:      J_NEXT,
    target:   ST_IDLE
  };

  function automatic cw_t ucode(step_t s);
    cw_t cw;
    cw = CW_NOP;
    unique case (s)
      ST_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.jmp    = J_WAIT_IN;
      end
      ST_LOAD: begin
        cw.ld_delay = 1'b1;
        cw.acc_op   = ACC_LDX;
        cw.jmp      = J_CHK_CH;
        cw.target   = ST_OUT;
      end
      ST_MA1: begin
        cw.coef_sel = C_A1;
        cw.opd_sel  = O_W1;
      end
      ST_SA1: begin
        cw.acc_op   = ACC_SUB;
        cw.coef_sel = C_A2;
        cw.opd_sel  = O_W2;
      end
      ST_SA2: begin
        cw.acc_op   = ACC_SUB;
        cw.coef_sel = C_B1;
        cw.opd_sel  = O_W1;
      end
      ST_RW: begin
        cw.ld_w     = 1'b1;
        cw.acc_op   = ACC_LDP;
        cw.coef_sel = C_B2;
        cw.opd_sel  = O_W2;
      end
      ST_AB2: begin
        cw.acc_op   = ACC_ADD;
        cw.coef_sel = C_B0;
        cw.opd_sel  = O_W;
      end
      ST_AB0: begin
        cw.acc_op = ACC_ADD;
        cw.ram_we = 1'b1;
      end
      ST_OUT: begin
        cw.out_ld = 1'b1;
        cw.jmp    = J_WAIT_OUT;
        cw.target = ST_IDLE;
      end
      default: begin
        cw.jmp    = J_GOTO;
        cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/biquad_df2_allpass_filter.sv =====
// channel  direction  handshake                 payload
// in_      input      in_valid / in_stall       in_data   (sample_in, chan_in)
// out_     output     out_valid / out_stall     out_data  (sample_out, chan_out)
// cfg_     input      cfg_we                    cfg_idx, cfg_wdata
//
// from its input beat to its result in the output register a sample runs the steps
// LOAD to OUT of the microcode program, with the five products sharing one multiplier
// the next input beat can be taken from the cycle after the result is loaded
// reset sets b0 to 1.0, the other taps to zero and marks every channel delay as zero
// out_stall holds the program at its output step until the output register is free
module biquad_df2_allpass_filter
  import bqap_pkg::*;
#(
  parameter int NUM_CHANNELS   = BQ_NUM_CHANNELS,
  parameter int COEF_FRAC_BITS = BQ_COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cw_t       cw;
  seq_stat_t st;

  coef_t coef_r;
  coef_t coef_nxt;

  in_beat_t item_r;
  logic     in_accept;
  logic     ch_ok;

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [2*STATE_W-1:0]   rd_data;
  logic [2*STATE_W-1:0]   wr_data;
  logic                   ram_we;
  logic                   rd_hit;
  logic [NUM_CHANNELS-1:0] ch_valid_r;
  logic [NUM_CHANNELS-1:0] ch_valid_nxt;

  logic signed [SAMPLE_BITS-1:0] y;

  logic      out_free;
  logic      out_go;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_beat_t out_data_r;

  assign in_stall  = !cw.in_rdy;
  assign in_accept = in_valid && cw.in_rdy;

  assign ch_ok = ({{(32-CHAN_W){1'b0}}, item_r.chan_in} < 32'(NUM_CHANNELS));

  assign out_free = !out_valid_r || !out_stall;
  assign out_go   = cw.out_ld && out_free;

  assign st.in_valid = in_valid;
  assign st.ch_ok    = ch_ok;
  assign st.out_free = out_free;

  // coefficient registers
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_B0:  coef_nxt.b0 = cfg_wdata;
        REG_B1:  coef_nxt.b1 = cfg_wdata;
        REG_B2:  coef_nxt.b2 = cfg_wdata;
        REG_A1:  coef_nxt.a1 = cfg_wdata;
        REG_A2:  coef_nxt.a2 = cfg_wdata;
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= COEF_W'(32768);
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // delay store: {w1, w2} per channel, valid bits stand in for the reset clear
  assign rd_addr = AW'(in_data.chan_in);
  assign wr_addr = AW'(item_r.chan_in);
  assign ram_we  = cw.ram_we;
  assign rd_hit  = ch_ok && ch_valid_r[wr_addr];

  always_comb begin
    ch_valid_nxt = ch_valid_r;
    if (ram_we) begin
      ch_valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= '0;
    end else begin
      ch_valid_r <= ch_valid_nxt;
    end
  end

  bqap_ram #(
    .WIDTH(2*STATE_W),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (in_accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  bqap_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .cw   (cw)
  );

  bqap_dp #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .cw     (cw),
    .coef   (coef_r),
    .x      (item_r.sample_in),
    .rd_data(rd_data),
    .rd_hit (rd_hit),
    .wr_data(wr_data),
    .y      (y)
  );

  // output register
  always_comb begin
    if (out_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      out_data_r.sample_out <= ch_ok ? y : '0;
      out_data_r.chan_out   <= item_r.chan_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !cw.in_rdy)
    else $error("input taken again right after a beat");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ch_ok)
    else $error("delay write for a channel out of range");

  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> ch_valid_r[$past(wr_addr)])
    else $error("channel not marked valid after delay write");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_go |=> out_valid_r && !cw.out_ld)
    else $error("result load did not raise out_valid or program stuck");
`endif

endmodule

// ===== rtl/bqap_ram.sv =====
module bqap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bqap_seq.sv =====
module bqap_seq
  import bqap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t st,
  output cw_t       cw
);

  step_t pc_r;
  step_t pc_nxt;

  assign cw = ucode(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    pc_nxt = pc_r + step_t'(1);
    unique case (cw.jmp)
      J_NEXT:     pc_nxt = pc_r + step_t'(1);
      J_GOTO:     pc_nxt = cw.target;
      J_WAIT_IN:  pc_nxt = st.in_valid ? pc_r + step_t'(1) : pc_r;
      J_CHK_CH:   pc_nxt = st.ch_ok ? pc_r + step_t'(1) : cw.target;
      J_WAIT_OUT: pc_nxt = st.out_free ? cw.target : pc_r;
      default:    pc_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bqap_dp.sv =====
module bqap_dp
  import bqap_pkg::*;
#(
  parameter int COEF_FRAC_BITS = BQ_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  cw_t                           cw,
  input  coef_t                         coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [2*STATE_W-1:0]   rd_data,
  input  logic                          rd_hit,
  output logic        [2*STATE_W-1:0]   wr_data,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int PROD_W = COEF_W + STATE_W;
  localparam int XS_W   = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int ACC_W  = ((XS_W > PROD_W) ? XS_W : PROD_W) + 3;

  localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] W_MAX = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  logic signed [STATE_W-1:0] w1_r;
  logic signed [STATE_W-1:0] w2_r;
  logic signed [STATE_W-1:0] w_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [COEF_W-1:0]  mul_c;
  logic signed [STATE_W-1:0] mul_d;
  logic signed [ACC_W-1:0]   x_ext;
  logic signed [ACC_W-1:0]   p_ext;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [STATE_W-1:0] w_sat;

  assign x_ext = ACC_W'(x);
  assign p_ext = ACC_W'(prod_r);

  always_comb begin
    unique case (cw.coef_sel)
      C_B0:    mul_c = coef.b0;
      C_B1:    mul_c = coef.b1;
      C_B2:    mul_c = coef.b2;
      C_A1:    mul_c = coef.a1;
      C_A2:    mul_c = coef.a2;
      default: mul_c = coef.b0;
    endcase
    unique case (cw.opd_sel)
      O_W1:    mul_d = w1_r;
      O_W2:    mul_d = w2_r;
      O_W:     mul_d = w_r;
      default: mul_d = w1_r;
    endcase
  end

  assign prod_nxt = mul_c * mul_d;

  always_comb begin
    unique case (cw.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LDX:  acc_nxt = x_ext <<< COEF_FRAC_BITS;
      ACC_SUB:  acc_nxt = acc_r - p_ext;
      ACC_LDP:  acc_nxt = p_ext;
      ACC_ADD:  acc_nxt = acc_r + p_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  // round half up, then clamp
  assign rnd = (acc_r + BIAS) >>> COEF_FRAC_BITS;

  always_comb begin
    if (rnd > W_MAX) begin
      w_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end else if (rnd < W_MIN) begin
      w_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      w_sat = rnd[STATE_W-1:0];
    end
    if (rnd > Y_MAX) begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (rnd < Y_MIN) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cw.ld_delay) begin
      w1_r <= rd_hit ? rd_data[2*STATE_W-1:STATE_W] : '0;
      w2_r <= rd_hit ? rd_data[STATE_W-1:0] : '0;
    end
    if (cw.ld_w) begin
      w_r <= w_sat;
    end
  end

  assign wr_data = {w_r, w1_r};

endmodule

// ===== tb/biquad_df2_allpass_filter_tb.sv =====
`timescale 1ns / 1ps

module biquad_df2_allpass_filter_tb;
  import bqap_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 153;
  localparam int HOLD_PHASE      = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 14;
  localparam int WATCHDOG_LIMIT  = 3000;

  localparam int COEF_MIN = -(1 << (COEF_W - 1));
  localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_ONE = 1 << BQ_COEF_FRAC_BITS;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));
  localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;

  // indexes past the last coefficient register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 3'd7;

  typedef enum logic {DIR_SAMPLE, DIR_COEF} dir_kind_t;
  typedef enum {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;
  typedef enum {SET_ALLPASS, SET_RANDOM, SET_EXTREME} coef_set_t;

  typedef struct packed {
    dir_kind_t                     kind;
    logic [CFG_IDX_W-1:0]          sel;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] want;
  } dir_row_t;

  // sel is the channel for a sample row and the register index for a coefficient row
  localparam dir_row_t DIRECTED [28] = '{
    '{DIR_SAMPLE, 3'd0, 0,          1'b1, 0},
    '{DIR_SAMPLE, 3'd7, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
    '{DIR_SAMPLE, 3'd0, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
    '{DIR_SAMPLE, 3'd3, -1,         1'b1, -1},
    '{DIR_SAMPLE, 3'd5, 1,          1'b1, 1},
    '{DIR_SAMPLE, 3'd2, 5592405,    1'b1, 5592405},
    '{DIR_SAMPLE, 3'd6, -5592406,   1'b1, -5592406},
    '{DIR_SAMPLE, 3'd1, 4660,       1'b1, 4660},
    '{DIR_COEF,   REG_SPARE_0, 0,        1'b0, 0},
    '{DIR_COEF,   REG_SPARE_1, COEF_MIN, 1'b0, 0},
    '{DIR_COEF,   REG_SPARE_2, COEF_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd1, -4660,      1'b1, -4660},
    '{DIR_COEF,   REG_B0, COEF_MAX, 1'b0, 0},
    '{DIR_COEF,   REG_B1, COEF_MIN, 1'b0, 0},
    '{DIR_COEF,   REG_B2, COEF_MAX, 1'b0, 0},
    '{DIR_COEF,   REG_A1, COEF_MIN, 1'b0, 0},
    '{DIR_COEF,   REG_A2, COEF_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, SAMPLE_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, SAMPLE_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, SAMPLE_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, SAMPLE_MIN, 1'b0, 0},
    '{DIR_COEF,   REG_B0, COEF_MIN, 1'b0, 0},
    '{DIR_COEF,   REG_A1, COEF_MAX, 1'b0, 0},
    '{DIR_COEF,   REG_A2, COEF_MIN, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, SAMPLE_MIN, 1'b0, 0},
    '{DIR_SAMPLE, 3'd0, SAMPLE_MAX, 1'b0, 0},
    '{DIR_SAMPLE, 3'd7, SAMPLE_MIN, 1'b0, 0},
    '{DIR_SAMPLE, 3'd4, 0,          1'b0, 0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  biquad_df2_allpass_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // filter state mirrored from the block
  coef_t coef_copy = '{b0: COEF_W'(COEF_ONE), default: '0};
  logic signed [STATE_W-1:0] w1_state [BQ_NUM_CHANNELS] = '{default: '0};
  logic signed [STATE_W-1:0] w2_state [BQ_NUM_CHANNELS] = '{default: '0};

  out_beat_t pending_out [$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        hold_req = 0;
  int        holds_done = 0;
  int        hold_left = 0;
  int        mode_left = 0;
  rx_mode_t  rx_mode = RX_FREE;
  int        quiet = 0;

  function automatic longint round_q(longint v);
    return (v + (longint'(1) <<< (BQ_COEF_FRAC_BITS - 1))) >>> BQ_COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic out_beat_t filter_sample(in_beat_t b);
    longint    x, w1, w2, acc, wn, yn;
    longint    cb0, cb1, cb2, ca1, ca2;
    int        ch;
    out_beat_t r;
    ch = int'(b.chan_in);
    r.chan_out   = b.chan_in;
    r.sample_out = '0;
    if (ch >= BQ_NUM_CHANNELS) return r;
    cb0 = longint'(coef_copy.b0);
    cb1 = longint'(coef_copy.b1);
    cb2 = longint'(coef_copy.b2);
    ca1 = longint'(coef_copy.a1);
    ca2 = longint'(coef_copy.a2);
    x  = longint'(b.sample_in);
    w1 = longint'(w1_state[ch]);
    w2 = longint'(w2_state[ch]);
    acc = (x <<< BQ_COEF_FRAC_BITS) - ca1 * w1 - ca2 * w2;
    wn  = clamp(round_q(acc), STATE_W);
    acc = cb0 * wn + cb1 * w1 + cb2 * w2;
    yn  = clamp(round_q(acc), SAMPLE_BITS);
    w2_state[ch] = w1_state[ch];
    w1_state[ch] = wn[STATE_W-1:0];
    r.sample_out = yn[SAMPLE_BITS-1:0];
    return r;
  endfunction

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    if (pending_out.size() == 0) begin
      $error("unexpected result beat: sample_out %0d chan_out %0d",
             $signed(got.sample_out), got.chan_out);
      mismatches++;
      return;
    end
    want = pending_out.pop_front();
    if (got.sample_out !== want.sample_out) begin
      $error("sample_out: expected %0d, got %0d", $signed(want.sample_out),
             $signed(got.sample_out));
      mismatches++;
    end
    if (got.chan_out !== want.chan_out) begin
      $error("chan_out: expected %0d, got %0d", want.chan_out, got.chan_out);
      mismatches++;
    end
  endtask

  // result side: checks, stall pattern and the long hold
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != hold_req) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        default:  out_stall <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic pace_after_beat();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 25 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_sample(in_beat_t b, logic typed, logic signed [SAMPLE_BITS-1:0] want);
    out_beat_t exp_beat;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    exp_beat = filter_sample(b);
    if (typed) exp_beat.sample_out = want;
    pending_out.push_back(exp_beat);
    pace_after_beat();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_B0:  coef_copy.b0 = val;
      REG_B1:  coef_copy.b1 = val;
      REG_B2:  coef_copy.b2 = val;
      REG_A1:  coef_copy.a1 = val;
      REG_A2:  coef_copy.a2 = val;
      default: ;
    endcase
  endtask

  function automatic int extreme_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return 0;
      default: return COEF_ONE;
    endcase
  endfunction

  task automatic load_coefs(coef_set_t kind);
    int b0, b1, b2, a1, a2;
    case (kind)
      SET_ALLPASS: begin
        // stable all-pass: poles inside the stability triangle
        a2 = $urandom_range(0, 32000);
        a1 = $urandom_range(0, COEF_ONE + a2 - 1);
        if ($urandom_range(0, 1)) a1 = -a1;
        b0 = a2;
        b1 = a1;
        b2 = COEF_ONE;
      end
      SET_RANDOM: begin
        b0 = $urandom_range(0, 2 * COEF_MAX + 1);
        b1 = $urandom_range(0, 2 * COEF_MAX + 1);
        b2 = $urandom_range(0, 2 * COEF_MAX + 1);
        a1 = $urandom_range(0, 2 * COEF_MAX + 1);
        a2 = $urandom_range(0, 2 * COEF_MAX + 1);
        write_coef(REG_SPARE_0, COEF_W'($urandom));
        write_coef(REG_SPARE_1, COEF_W'($urandom));
        write_coef(REG_SPARE_2, COEF_W'($urandom));
      end
      default: begin
        b0 = extreme_coef();
        b1 = extreme_coef();
        b2 = extreme_coef();
        a1 = extreme_coef();
        a2 = extreme_coef();
      end
    endcase
    write_coef(REG_B0, COEF_W'(b0));
    write_coef(REG_B1, COEF_W'(b1));
    write_coef(REG_B2, COEF_W'(b2));
    write_coef(REG_A1, COEF_W'(a1));
    write_coef(REG_A2, COEF_W'(a2));
    cfg_we <= 1'b0;
  endtask

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.chan_in = CHAN_W'($urandom_range(0, BQ_NUM_CHANNELS - 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b.sample_in = SAMPLE_BITS'($urandom);
      5, 6:          b.sample_in = SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
      7, 8:          b.sample_in = SAMPLE_BITS'($urandom_range(0, 1 << 21) - (1 << 20));
      default:       b.sample_in = SAMPLE_BITS'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
    endcase
    return b;
  endfunction

  initial begin
    in_beat_t  b;
    coef_set_t kind;
    logic      in_cfg;
    in_cfg = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == DIR_COEF) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        write_coef(DIRECTED[i].sel, DIRECTED[i].value[COEF_W-1:0]);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        b.sample_in = DIRECTED[i].value;
        b.chan_in   = DIRECTED[i].sel;
        send_sample(b, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 5)
        0:       kind = SET_EXTREME;
        3:       kind = SET_RANDOM;
        default: kind = SET_ALLPASS;
      endcase
      load_coefs(kind);
      // long result-side hold while beats keep coming
      if (ph == HOLD_PHASE) hold_req <= hold_req + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(random_beat(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
